>>> src/vpwb_pkg.sv
// Package: shared constants and helper functions of the Verlet wall-bounce particle block.
`timescale 1ns / 1ps

package vpwb_pkg;

	// Fraction bits of positions, radius and gravity.
	localparam int FRAC_BITS = 16;

	// Working width of the signed intermediate sums; wide enough for a wall at full width.
	localparam int WIDE_W = (FRAC_BITS + 14 > 36) ? FRAC_BITS + 14 : 36;

	// Widths of the shared multiplier.
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Q0.16 loss and damping factors.
	localparam logic [15:0] DAMP_Q16  = 16'd64815;
	localparam logic [15:0] SIDE_Q16  = 16'd29491;
	localparam logic [15:0] FLOOR_Q16 = 16'd42598;

	// Snap threshold of the horizontal velocity, floor(0.0099999 * 2^FRAC_BITS).
	localparam longint THRESH_FULL = (longint'(99999) << FRAC_BITS) / 10000000;
	localparam logic [33:0] THRESH_LIM = 34'(THRESH_FULL);

	// Configuration register indices.
	localparam logic [2:0] CFG_WIDTH   = 3'd0;
	localparam logic [2:0] CFG_HEIGHT  = 3'd1;
	localparam logic [2:0] CFG_RADIUS  = 3'd2;
	localparam logic [2:0] CFG_GRAVITY = 3'd3;
	localparam logic [2:0] CFG_PINNED  = 3'd4;
	localparam logic [2:0] CFG_START_X = 3'd5;
	localparam logic [2:0] CFG_START_Y = 3'd6;

	// Sign extension of a 32 bit position to the working width.
	function automatic logic signed [WIDE_W-1:0] sx32(input logic signed [31:0] v);
		return {{(WIDE_W-32){v[31]}}, v};
	endfunction

	// Saturation of a working value to the signed 32 bit range.
	function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = {{(WIDE_W-32){1'b0}}, 32'h7FFF_FFFF};
		lo = {{(WIDE_W-32){1'b1}}, 32'h8000_0000};
		if (v > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// Magnitude of a working value; velocities never exceed 2^32 in size.
	function automatic logic [MUL_A_W-1:0] mag33(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] n;
		n = -v;
		return v[WIDE_W-1] ? n[MUL_A_W-1:0] : v[MUL_A_W-1:0];
	endfunction

	// Product with a Q0.16 factor, shifted down and rounded half up on the magnitude.
	function automatic logic [33:0] rnd_q16(input logic [MUL_P_W-1:0] p);
		logic [49:0] s;
		s = {1'b0, p[48:0]} + 50'd32768;
		return s[49:16];
	endfunction

endpackage

>>> src/vpwb_if.sv
// Interfaces: the tick input channel and the position result channel.
`timescale 1ns / 1ps

interface vpwb_in_if;
	logic        valid;
	logic        ready;
	logic        restart;
	logic [15:0] dt;

	modport source (output valid, output restart, output dt, input ready);
	modport sink (input valid, input restart, input dt, output ready);
endinterface

interface vpwb_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic               colliding;

	modport source (output valid, output pos_x, output pos_y, output colliding, input ready);
	modport sink (input valid, input pos_x, input pos_y, input colliding, output ready);
endinterface

>>> src/vpwb_mul.sv
// Shared unsigned multiplier with a registered product.
`timescale 1ns / 1ps

module vpwb_mul (
	input  logic                          clk,
	input  logic [vpwb_pkg::MUL_A_W-1:0]  a,
	input  logic [vpwb_pkg::MUL_B_W-1:0]  b,
	output logic [vpwb_pkg::MUL_P_W-1:0]  p_q
);

	always_ff @(posedge clk) begin
		p_q <= vpwb_pkg::MUL_P_W'(a) * vpwb_pkg::MUL_P_W'(b);
	end

endmodule

>>> src/verlet_particle_wall_bounce_top.sv
// Top level: sequencer, state and configuration of the Verlet wall-bounce particle.
`timescale 1ns / 1ps

// One ball is advanced by one tick per transfer on the input channel. A tick with restart set
// loads the start position into the current and previous position and returns it, with
// colliding low, from the output state. Otherwise the block integrates position Verlet
// under gravity, damps and snaps the horizontal velocity, then tests the walls in the order
// left, right, top, floor and bounces off the first one hit. Every product goes through one
// shared multiplier, so the sequencer issues each from its own state: dt squared, gravity times dt
// squared, the damping of the horizontal velocity and, on a hit, the loss on the bounce. A
// normal tick runs through the states SQ, GRAV, VEL, INT and COLL, then BNC on a bounce, and
// OUT; a pinned ball skips the three integration products and goes from IDLE to COLL.
// The input channel is ready only while the sequencer is idle, and a finished result waits
// in an output register, so the next tick can be taken while the previous result is still
// waiting to be collected. Configuration writes are meant for idle periods; a new start
// position only takes effect at the next restart.

module verlet_particle_wall_bounce_top (
	input  logic               clk,
	input  logic               arst_n,
	vpwb_in_if.sink            in_ch,
	vpwb_out_if.source         out_ch,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_SQ   = 8'b0000_0010,
		S_GRAV = 8'b0000_0100,
		S_VEL  = 8'b0000_1000,
		S_INT  = 8'b0001_0000,
		S_COLL = 8'b0010_0000,
		S_BNC  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	localparam int WW = vpwb_pkg::WIDE_W;

	state_t state_q;

	// Configuration registers.
	logic [11:0]        width_q;
	logic [11:0]        height_q;
	logic [24:0]        radius_q;
	logic [30:0]        grav_q;
	logic               pinned_q;
	logic signed [31:0] start_x_q;
	logic signed [31:0] start_y_q;

	// Particle state.
	logic signed [31:0] pos_x_q;
	logic signed [31:0] pos_y_q;
	logic signed [31:0] prev_x_q;
	logic signed [31:0] prev_y_q;

	// Working registers of the tick in flight.
	logic [15:0]        dt_q;
	logic signed [31:0] nx_q;
	logic signed [31:0] ny_q;
	logic               neg_q;
	logic               axis_y_q;
	logic               hit_q;

	// Output register.
	logic               out_valid_q;
	logic signed [31:0] out_x_q;
	logic signed [31:0] out_y_q;
	logic               out_hit_q;

	logic [vpwb_pkg::MUL_A_W-1:0] mul_a;
	logic [vpwb_pkg::MUL_B_W-1:0] mul_b;
	logic [vpwb_pkg::MUL_P_W-1:0] mul_p;

	logic in_acc;
	logic out_free;

	assign in_ch.ready     = (state_q == S_IDLE);
	assign in_acc          = in_ch.valid && in_ch.ready;
	assign out_free        = !out_valid_q || out_ch.ready;
	assign out_ch.valid    = out_valid_q;
	assign out_ch.pos_x    = out_x_q;
	assign out_ch.pos_y    = out_y_q;
	assign out_ch.colliding = out_hit_q;

	// Integration arithmetic around the multiplier.
	logic signed [WW-1:0] ox_w, oy_w, px_w, py_w;
	logic signed [WW-1:0] nx_w, ny_w;
	logic [63:0]          g_sum;
	logic signed [WW-1:0] g_w;
	logic signed [WW-1:0] dvx_w;
	logic [33:0]          vmag;
	logic signed [WW-1:0] vx_w;

	assign ox_w  = vpwb_pkg::sx32(pos_x_q);
	assign oy_w  = vpwb_pkg::sx32(pos_y_q);
	assign px_w  = vpwb_pkg::sx32(prev_x_q);
	assign py_w  = vpwb_pkg::sx32(prev_y_q);
	assign nx_w  = (ox_w <<< 1) - px_w;
	// Gravity times dt squared is Q16.16 by Q0.32, rounded to nearest on the way down.
	assign g_sum = mul_p[63:0] + 64'h0000_0000_8000_0000;
	assign g_w   = WW'(g_sum[62:32]);
	assign ny_w  = (oy_w <<< 1) - py_w + g_w;
	assign dvx_w = vpwb_pkg::sx32(nx_q) - ox_w;
	assign vmag  = vpwb_pkg::rnd_q16(mul_p);

	// A damped velocity at or below the threshold is snapped to rest.
	always_comb begin
		vx_w = '0;
		if (vmag > vpwb_pkg::THRESH_LIM) begin
			vx_w = neg_q ? -WW'(vmag) : WW'(vmag);
		end
	end

	// Wall tests on the integrated position.
	logic signed [WW-1:0] r_w, wr_w, fl_w;
	logic signed [WW-1:0] vxc_w, vyc_w;
	logic hit_l, hit_r, hit_t, hit_f;
	logic signed [WW-1:0] clamp_w;
	logic signed [WW-1:0] vel_sel;
	logic [15:0]          k_sel;

	assign r_w   = WW'(radius_q);
	assign wr_w  = WW'(width_q) <<< vpwb_pkg::FRAC_BITS;
	assign fl_w  = WW'(height_q) <<< vpwb_pkg::FRAC_BITS;
	assign vxc_w = ox_w - px_w;
	assign vyc_w = oy_w - py_w;
	assign hit_l = ox_w < r_w;
	assign hit_r = (ox_w + r_w) > wr_w;
	assign hit_t = oy_w < r_w;
	assign hit_f = (oy_w + r_w) > fl_w;

	always_comb begin
		clamp_w = r_w;
		if (!hit_l && hit_r) begin
			clamp_w = wr_w - r_w;
		end else if (!hit_l && !hit_r && !hit_t) begin
			clamp_w = fl_w - r_w;
		end
	end

	assign vel_sel = (hit_l || hit_r) ? vxc_w : vyc_w;
	assign k_sel   = (hit_l || hit_r) ? vpwb_pkg::SIDE_Q16 : vpwb_pkg::FLOOR_Q16;

	// Bounce: the previous position is set behind the clamped one by the lossy velocity.
	logic signed [WW-1:0] m_w;
	logic signed [WW-1:0] base_w;

	assign m_w    = neg_q ? -WW'(vmag) : WW'(vmag);
	assign base_w = axis_y_q ? oy_w : ox_w;

	// Operand selection of the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ: begin
				mul_a = vpwb_pkg::MUL_A_W'(dt_q);
				mul_b = vpwb_pkg::MUL_B_W'(dt_q);
			end
			S_GRAV: begin
				mul_a = vpwb_pkg::MUL_A_W'(grav_q);
				mul_b = mul_p[vpwb_pkg::MUL_B_W-1:0];
			end
			S_VEL: begin
				mul_a = vpwb_pkg::mag33(dvx_w);
				mul_b = vpwb_pkg::MUL_B_W'(vpwb_pkg::DAMP_Q16);
			end
			S_COLL: begin
				mul_a = vpwb_pkg::mag33(vel_sel);
				mul_b = vpwb_pkg::MUL_B_W'(k_sel);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	vpwb_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= 12'd800;
			height_q  <= 12'd600;
			radius_q  <= 25'd655360;
			grav_q    <= 31'd7929856;
			pinned_q  <= 1'b0;
			start_x_q <= '0;
			start_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vpwb_pkg::CFG_WIDTH:   width_q   <= cfg_data[11:0];
				vpwb_pkg::CFG_HEIGHT:  height_q  <= cfg_data[11:0];
				vpwb_pkg::CFG_RADIUS:  radius_q  <= cfg_data[24:0];
				vpwb_pkg::CFG_GRAVITY: grav_q    <= cfg_data[30:0];
				vpwb_pkg::CFG_PINNED:  pinned_q  <= cfg_data[0];
				vpwb_pkg::CFG_START_X: start_x_q <= cfg_data;
				vpwb_pkg::CFG_START_Y: start_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and particle state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// In the output state a collected result is replaced by the new one below.
			if (out_valid_q && out_ch.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						dt_q  <= in_ch.dt;
						hit_q <= 1'b0;
						if (in_ch.restart) begin
							pos_x_q  <= start_x_q;
							pos_y_q  <= start_y_q;
							prev_x_q <= start_x_q;
							prev_y_q <= start_y_q;
							state_q  <= S_OUT;
						end else if (pinned_q) begin
							state_q <= S_COLL;
						end else begin
							state_q <= S_SQ;
						end
					end
				end
				S_SQ: begin
					state_q <= S_GRAV;
				end
				S_GRAV: begin
					nx_q    <= vpwb_pkg::sat32(nx_w);
					state_q <= S_VEL;
				end
				S_VEL: begin
					ny_q    <= vpwb_pkg::sat32(ny_w);
					neg_q   <= dvx_w[WW-1];
					state_q <= S_INT;
				end
				S_INT: begin
					pos_x_q  <= nx_q;
					pos_y_q  <= ny_q;
					prev_x_q <= vpwb_pkg::sat32(vpwb_pkg::sx32(nx_q) - vx_w);
					prev_y_q <= pos_y_q;
					state_q  <= S_COLL;
				end
				S_COLL: begin
					if (hit_l || hit_r || hit_t || hit_f) begin
						hit_q    <= 1'b1;
						axis_y_q <= !(hit_l || hit_r);
						neg_q    <= vel_sel[WW-1];
						if (hit_l || hit_r) begin
							pos_x_q <= vpwb_pkg::sat32(clamp_w);
						end else begin
							pos_y_q <= vpwb_pkg::sat32(clamp_w);
						end
						state_q <= S_BNC;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_BNC: begin
					if (axis_y_q) begin
						prev_y_q <= vpwb_pkg::sat32(base_w + m_w);
					end else begin
						prev_x_q <= vpwb_pkg::sat32(base_w + m_w);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_x_q     <= pos_x_q;
						out_y_q     <= pos_y_q;
						out_hit_q   <= hit_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A restart tick loads the start position straight away.
	a_restart_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_ch.restart |=> pos_x_q == $past(start_x_q) && prev_y_q == $past(start_y_q))
		else $error("restart did not load the start position");

	// A pinned ball goes straight to the wall test.
	a_pinned_skip: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !in_ch.restart && pinned_q |=> state_q == S_COLL)
		else $error("pinned tick entered integration");

	// A new result only appears after the output state.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output state");

	// The bounce step only runs after a wall was hit.
	a_bounce_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BNC |-> hit_q)
		else $error("bounce without a wall hit");

endmodule
